### hw/rtl/rolling_hash_pattern_search_defines.svh
// ----------------------------------------------------------------------------
// Rolling hash pattern search - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_PATTERN_SEARCH_DEFINES_SVH
`define ROLLING_HASH_PATTERN_SEARCH_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define RHPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be seen outside reset.
`define RHPS_ASSERT_NEVER(lbl, cond, msg) \
	`RHPS_ASSERT(lbl, !(cond), msg)

`endif

### hw/rtl/rhps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling hash pattern search - package
// Hash constants, residue tables, shared types and the register map.
// ----------------------------------------------------------------------------
package rhps_pkg;

	localparam int HashMod    = 5381;
	localparam int MaxPattern = 16;
	localparam int LenW       = $clog2(MaxPattern + 1);
	localparam int IdxW       = $clog2(MaxPattern);
	localparam int HashW      = 13;
	localparam int SumW       = 15;
	localparam int DataW      = 64;
	localparam int AddrW      = 5;

	typedef logic [HashW-1:0] res_t;
	typedef res_t tbl8_t  [256];
	typedef res_t tbl16_t [32];
	typedef res_t pow_t   [MaxPattern+1];

	typedef enum logic [1:0] {
		RegPatternLow    = 2'd0,
		RegPatternHigh   = 2'd1,
		RegPatternLength = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [MaxPattern-1:0][7:0] pattern;
		logic [LenW-1:0]            len;
		res_t                       pat_hash;
		res_t                       drop_weight;
	} cfg_t;

	function automatic tbl8_t build_tbl8();
		tbl8_t t;
		for (int k = 0; k < 256; k++) begin
			t[k] = res_t'((k * 256) % HashMod);
		end
		return t;
	endfunction

	function automatic tbl16_t build_tbl16();
		tbl16_t t;
		for (int k = 0; k < 32; k++) begin
			t[k] = res_t'((k * 65536) % HashMod);
		end
		return t;
	endfunction

	function automatic pow_t build_pow();
		pow_t t;
		int p;
		p = 1;
		for (int k = 0; k <= MaxPattern; k++) begin
			t[k] = res_t'(p);
			p = (p * 256) % HashMod;
		end
		return t;
	endfunction

	// k*2^8 and k*2^16 reduced modulo the hash base.
	localparam tbl8_t  Shift8Tbl  = build_tbl8();
	localparam tbl16_t Shift16Tbl = build_tbl16();
	// 256^k reduced modulo the hash base.
	localparam pow_t   PowTbl     = build_pow();

	// Brings a value below three times the base into the residue range.
	function automatic res_t mod_reduce(input logic [SumW-1:0] v);
		res_t r;
		if (v >= SumW'(2 * HashMod)) begin
			r = res_t'(v - SumW'(2 * HashMod));
		end else if (v >= SumW'(HashMod)) begin
			r = res_t'(v - SumW'(HashMod));
		end else begin
			r = res_t'(v);
		end
		return r;
	endfunction

	// (256*h + b) mod base for any 13-bit h, by table lookup on the two parts of h.
	function automatic res_t mul256_add(input res_t h, input logic [7:0] b);
		return mod_reduce(SumW'(Shift16Tbl[h[12:8]]) + SumW'(Shift8Tbl[h[7:0]]) + SumW'(b));
	endfunction

endpackage

### hw/rtl/rolling_hash_pattern_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling hash pattern search - top level
// Searches a byte stream for a configured pattern of up to 16 bytes with a
// radix-256, modulo-5381 rolling hash and a byte-wise confirmation.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   text_byte, first_of_text, last_of_text
//   output   out_valid / out_stall match_found, match_start, no_match, window_hash
//   config   APB psel/penable      paddr, pwdata, prdata (registers at 8*i)
//
// One item per cycle while neither a pattern rebuild nor out_stall holds the
// flow; each item is captured in the input register and then moves to the
// result register, where it waits until it is taken. The hash update is a
// combinational loop through residue tables into the hash register.
// After any register write the pattern hash is rebuilt, one pattern byte a
// cycle for the effective pattern length, with in_stall high meanwhile.
// Reset clears the hash, byte count and match flag; the window is not cleared.
// A stalled result holds while the next item waits in the input register.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_search import rhps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       text_byte,
	input  logic             first_of_text,
	input  logic             last_of_text,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             match_found,
	output logic [31:0]      match_start,
	output logic             no_match,
	output logic [12:0]      window_hash
);

	cfg_t cfg;
	logic cfg_busy;

	rhps_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.cfg_busy (cfg_busy)
	);

	rhps_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cfg_busy      (cfg_busy),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.text_byte     (text_byte),
		.first_of_text (first_of_text),
		.last_of_text  (last_of_text),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.match_found   (match_found),
		.match_start   (match_start),
		.no_match      (no_match),
		.window_hash   (window_hash)
	);

endmodule

### hw/rtl/rhps_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling hash pattern search - configuration registers
// APB register file, effective length, drop weight and the pattern hash,
// which is rebuilt one pattern byte per cycle after every write.
// ----------------------------------------------------------------------------
module rhps_regs import rhps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg,
	output logic             cfg_busy
);

	logic [DataW-1:0] pat_low_q;
	logic [DataW-1:0] pat_high_q;
	logic [LenW-1:0]  len_q;
	logic             busy_q;
	logic [IdxW-1:0]  idx_q;
	res_t             phash_q;
	logic             wr_en;
	reg_idx_t         reg_idx;
	logic [LenW-1:0]  eff_len;
	logic [MaxPattern-1:0][7:0] pattern;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[AddrW-1:3]);
	assign pattern = {pat_high_q, pat_low_q};

	always_comb begin
		if (len_q == '0) begin
			eff_len = LenW'(1);
		end else if (len_q > LenW'(MaxPattern)) begin
			eff_len = LenW'(MaxPattern);
		end else begin
			eff_len = len_q;
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegPatternLow:    prdata = pat_low_q;
			RegPatternHigh:   prdata = pat_high_q;
			RegPatternLength: prdata = DataW'(len_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_q      <= LenW'(1);
			busy_q     <= 1'b0;
			idx_q      <= '0;
			phash_q    <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegPatternLow:    pat_low_q  <= pwdata;
				RegPatternHigh:   pat_high_q <= pwdata;
				RegPatternLength: len_q      <= pwdata[LenW-1:0];
				default:          ;
			endcase
			busy_q  <= 1'b1;
			idx_q   <= '0;
			phash_q <= '0;
		end else if (busy_q) begin
			phash_q <= mul256_add(phash_q, pattern[idx_q]);
			if ({1'b0, idx_q} == eff_len - LenW'(1)) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	assign cfg_busy        = busy_q;
	assign cfg.pattern     = pattern;
	assign cfg.len         = eff_len;
	assign cfg.pat_hash    = phash_q;
	// Adding this weight times the leaving byte removes it and shifts in one go.
	assign cfg.drop_weight = res_t'(HashMod) - PowTbl[eff_len];

endmodule

### hw/rtl/rhps_core.sv
`timescale 1ns / 1ps
`include "rolling_hash_pattern_search_defines.svh"
// ----------------------------------------------------------------------------
// Rolling hash pattern search - search datapath
// Input register, byte window, rolling hash, parallel byte compare and the
// result register.
// ----------------------------------------------------------------------------
module rhps_core import rhps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        cfg_busy,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        first_of_text,
	input  logic        last_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        match_found,
	output logic [31:0] match_start,
	output logic        no_match,
	output res_t        window_hash
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;

	logic [7:0]  window_q [MaxPattern];
	res_t        hash_q;
	logic [31:0] count_q;
	logic        matched_q;

	logic        out_valid_q;
	logic        found_q;
	logic [31:0] start_q;
	logic        none_q;
	res_t        whash_q;

	logic        adv;
	logic        in_acc;
	logic        item_go;
	res_t        hash_base;
	logic [31:0] count_base;
	logic        matched_base;
	logic        filling;
	logic [7:0]  drop_byte;
	logic [20:0] drop_prod;
	res_t        part_a;
	res_t        part_d;
	res_t        hash_new;
	logic [31:0] count_new;
	logic [7:0]  win_new [MaxPattern];
	logic [LenW-1:0] lane_sel [MaxPattern];
	logic [MaxPattern-1:0] lane_eq;
	logic        found_new;
	logic        matched_new;
	logic [31:0] start_new;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = cfg_busy || (valid_s1 && !adv);
	assign in_acc   = in_valid && !in_stall;
	assign item_go  = valid_s1 && adv;

	always_comb begin
		hash_base    = first_s1 ? '0 : hash_q;
		count_base   = first_s1 ? '0 : count_q;
		matched_base = first_s1 ? 1'b0 : matched_q;
		filling      = count_base < 32'(cfg.len);
		drop_byte    = window_q[IdxW'(cfg.len - LenW'(1))];
		drop_prod    = 21'(drop_byte) * 21'(cfg.drop_weight);
		part_a       = mul256_add(hash_base, byte_s1);
		part_d       = filling ? '0 : mul256_add(drop_prod[20:8], drop_prod[7:0]);
		hash_new     = mod_reduce(SumW'(part_a) + SumW'(part_d));
		count_new    = (count_base == 32'hFFFF_FFFF) ? count_base : count_base + 32'd1;
	end

	always_comb begin
		win_new[0] = byte_s1;
		for (int i = 1; i < MaxPattern; i++) begin
			win_new[i] = window_q[i-1];
		end
		// Window lane i holds the byte that pattern position len-1-i must match.
		for (int i = 0; i < MaxPattern; i++) begin
			lane_sel[i] = cfg.len - LenW'(1) - LenW'(i);
			lane_eq[i]  = (LenW'(i) >= cfg.len) ||
				(win_new[i] == cfg.pattern[lane_sel[i][IdxW-1:0]]);
		end
		found_new   = !matched_base && (count_new >= 32'(cfg.len)) &&
			(hash_new == cfg.pat_hash) && (&lane_eq);
		matched_new = matched_base || found_new;
		start_new   = found_new ? (count_new - 32'(cfg.len) + 32'd1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			hash_q      <= '0;
			count_q     <= '0;
			matched_q   <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !adv);
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (item_go) begin
				hash_q    <= hash_new;
				count_q   <= count_new;
				matched_q <= matched_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1  <= text_byte;
			first_s1 <= first_of_text;
			last_s1  <= last_of_text;
		end
		if (item_go) begin
			window_q <= win_new;
			found_q  <= found_new;
			start_q  <= start_new;
			none_q   <= last_s1 && !matched_new;
			whash_q  <= hash_new;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_found = found_q;
	assign match_start = start_q;
	assign no_match    = none_q;
	assign window_hash = whash_q;

	`RHPS_ASSERT(a_hash_in_range, hash_q < res_t'(HashMod), "rolling hash left the residue range")
	`RHPS_ASSERT(a_start_nonzero, (out_valid_q && found_q) |-> (start_q != '0), "match reported at position zero")
	`RHPS_ASSERT_NEVER(a_found_and_none, out_valid_q && found_q && none_q, "match and no-match on one item")
	`RHPS_ASSERT(a_matched_clear, $fell(matched_q) |-> $past(item_go && first_s1), "match flag cleared without a new text")

endmodule

### bench/rolling_hash_pattern_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rolling hash pattern search - testbench
// Streams texts through the search block and checks every result against a
// predictor that keeps its own window, hash, byte count and match flag.
// Directed texts cover defaults after reset, out-of-range lengths, a hash
// collision, short texts and a full-length pattern. Random phases then vary
// the pattern, plant true and colliding copies of it, break the framing now
// and then, and throttle both channels. One phase holds the result side off
// long enough for the block to fill up and stall its input.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_search_test;
	import rhps_pkg::*;

	localparam int Radix         = 256;
	localparam int HoldCycles    = 300;
	localparam int WatchdogLimit = 3000;
	localparam int ItemTarget    = 1000;
	localparam int MaxReports    = 40;

	typedef struct packed {
		logic        found;
		logic [31:0] start;
		logic        none;
		logic [12:0] hash;
	} search_result_t;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       text_byte;
	logic             first_of_text;
	logic             last_of_text;
	logic             out_valid;
	logic             out_stall;
	logic             match_found;
	logic [31:0]      match_start;
	logic             no_match;
	logic [12:0]      window_hash;

	rolling_hash_pattern_search DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.first_of_text(first_of_text),
		.last_of_text (last_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.match_found  (match_found),
		.match_start  (match_start),
		.no_match     (no_match),
		.window_hash  (window_hash)
	);

	// Predictor state: configuration copy and the running search of the current text.
	logic [63:0] pat_lo;
	logic [63:0] pat_hi;
	logic [4:0]  pat_len;
	logic [7:0]  text_window [MaxPattern];
	logic [12:0] run_hash;
	logic [31:0] seen_bytes;
	logic        matched_once;

	search_result_t expected_results [$];
	logic [7:0]     text_buf [$];

	bit idle_on;
	bit stall_on;
	bit hold_req;
	int n_sent;
	int n_checked;
	int n_found;
	int n_none;
	int n_cfg;
	int n_fail;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int active_len();
		int n;
		n = pat_len;
		if (n < 1) n = 1;
		if (n > MaxPattern) n = MaxPattern;
		return n;
	endfunction

	function automatic logic [7:0] pattern_byte(int j);
		return (j < 8) ? pat_lo[j*8 +: 8] : pat_hi[(j-8)*8 +: 8];
	endfunction

	function automatic int pattern_residue(int n);
		int h;
		h = 0;
		for (int j = 0; j < n; j++) h = (Radix * h + pattern_byte(j)) % HashMod;
		return h;
	endfunction

	// Weight of the oldest byte in a window of n bytes.
	function automatic int lead_weight(int n);
		int w;
		w = 1;
		for (int j = 1; j < n; j++) w = (w * Radix) % HashMod;
		return w;
	endfunction

	function automatic search_result_t predict_search_byte(logic [7:0] b, logic first,
			logic last);
		search_result_t r;
		int n;
		int h;
		int drop;
		bit same;
		r = '0;
		n = active_len();
		if (first) begin
			for (int k = 0; k < MaxPattern; k++) text_window[k] = 8'h00;
			run_hash = '0;
			seen_bytes = '0;
			matched_once = 1'b0;
		end
		h = int'(run_hash);
		if (seen_bytes < 32'(n)) begin
			h = (Radix * h + int'(b)) % HashMod;
		end else begin
			drop = (int'(text_window[n-1]) * lead_weight(n)) % HashMod;
			h = (h + HashMod - drop) % HashMod;
			h = (Radix * h + int'(b)) % HashMod;
		end
		run_hash = 13'(h);
		for (int k = MaxPattern - 1; k > 0; k--) text_window[k] = text_window[k-1];
		text_window[0] = b;
		if (seen_bytes != 32'hFFFF_FFFF) seen_bytes++;
		if (!matched_once && seen_bytes >= 32'(n) && h == pattern_residue(n)) begin
			same = 1'b1;
			for (int j = 0; j < n; j++) begin
				if (text_window[n-1-j] != pattern_byte(j)) same = 1'b0;
			end
			if (same) begin
				matched_once = 1'b1;
				r.found = 1'b1;
				r.start = seen_bytes - 32'(n) + 32'd1;
			end
		end
		if (last && !matched_once) r.none = 1'b1;
		r.hash = run_hash;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		if (n_fail < MaxReports)
			$display("mismatch in %s at result %0d: expected %0d, got %0d",
				field, n_checked, want, got);
		n_fail++;
	endtask

	// Result side: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		search_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (match_found === 1'b1) n_found++;
			if (no_match === 1'b1) n_none++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", 0, 32'(window_hash));
			end else begin
				want = expected_results.pop_front();
				if (match_found !== want.found)
					report_mismatch("match_found", 32'(want.found), 32'(match_found));
				if (match_start !== want.start)
					report_mismatch("match_start", want.start, match_start);
				if (no_match !== want.none)
					report_mismatch("no_match", 32'(want.none), 32'(no_match));
				if (window_hash !== want.hash)
					report_mismatch("window_hash", 32'(want.hash), 32'(window_hash));
			end
			n_checked++;
		end
	end

	// Receiver throttling, plus the long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_on && $urandom_range(0, 99) < 25) begin
				out_stall <= 1'b1;
				if ($urandom_range(0, 9) < 8) repeat ($urandom_range(1, 3)) @(posedge clk);
				else repeat ($urandom_range(10, 40)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic first, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		first_of_text <= first;
		last_of_text <= last;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_search_byte(b, first, last));
		n_sent++;
	endtask

	// Leaves the block with no item offered and every result delivered.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrW'(8 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			RegPatternLow: begin
				pat_lo = val;
			end
			RegPatternHigh: begin
				pat_hi = val;
			end
			RegPatternLength: begin
				pat_len = val[4:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(logic [63:0] lo, logic [63:0] hi, int len);
		write_reg(RegPatternLow, lo);
		write_reg(RegPatternHigh, hi);
		write_reg(RegPatternLength, 64'(len & 31));
		n_cfg++;
	endtask

	// Fills text_buf, with planted copies of the pattern and, at times, a copy
	// altered in two adjacent bytes so that its hash still agrees.
	task automatic build_text(int len, bit narrow);
		int n;
		int pos;
		int j;
		int a;
		int c;
		n = active_len();
		text_buf.delete();
		for (int i = 0; i < len; i++) begin
			if (narrow && $urandom_range(0, 1)) text_buf.push_back(pattern_byte($urandom_range(0, n-1)));
			else text_buf.push_back(8'($urandom_range(0, 255)));
		end
		if (len < n) return;
		repeat ($urandom_range(0, 2)) begin
			pos = $urandom_range(0, len - n);
			for (int k = 0; k < n; k++) text_buf[pos + k] = pattern_byte(k);
		end
		if (n >= 2 && $urandom_range(0, 99) < 35) begin
			pos = $urandom_range(0, len - n);
			j = $urandom_range(0, n - 2);
			for (int k = 0; k < n; k++) text_buf[pos + k] = pattern_byte(k);
			a = pattern_byte(j);
			c = pattern_byte(j + 1);
			if (a <= 234 && c <= 250) begin
				text_buf[pos + j] = 8'(a + 21);
				text_buf[pos + j + 1] = 8'(c + 5);
			end else if (a >= 21 && c >= 5) begin
				text_buf[pos + j] = 8'(a - 21);
				text_buf[pos + j + 1] = 8'(c - 5);
			end
		end
	endtask

	// Occasional stray first or last flags break the framing on purpose.
	task automatic send_text(bit with_first, bit with_last);
		int sz;
		logic f;
		logic l;
		sz = text_buf.size();
		for (int i = 0; i < sz; i++) begin
			f = (with_first && i == 0) || ($urandom_range(0, 199) == 0);
			l = (with_last && i == sz - 1) || ($urandom_range(0, 99) == 0);
			send_byte(text_buf[i], f, l);
		end
	endtask

	// Default one-byte zero pattern; the first bytes arrive with no first flag.
	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1);
	endtask

	// Length 0 acts as 1; then length 2 meets a window whose hash collides.
	task automatic test_short_patterns();
		wait_idle();
		set_config(64'h0000_0000_0000_2010, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_byte(8'h20, 1'b1, 1'b0);
		send_byte(8'h10, 1'b0, 1'b1);
		wait_idle();
		set_config(64'h0000_0000_0000_2010, 64'hFFFF_FFFF_FFFF_FFFF, 2);
		send_byte(8'h25, 1'b1, 1'b0);
		send_byte(8'h25, 1'b0, 1'b0);
		send_byte(8'h10, 1'b0, 1'b0);
		send_byte(8'h20, 1'b0, 1'b1);
		send_byte(8'h10, 1'b1, 1'b1);
	endtask

	task automatic test_full_length();
		wait_idle();
		set_config(64'h00FF_00FF_00FF_00FF, 64'h00FF_00FF_00FF_00FF, MaxPattern);
		for (int i = 0; i < MaxPattern; i++)
			send_byte((i % 2 == 0) ? 8'hFF : 8'h00, i == 0, i == MaxPattern - 1);
	endtask

	// The receiver stops for a long stretch while items keep being offered.
	task automatic test_output_hold_off();
		wait_idle();
		set_config({$urandom, $urandom}, {$urandom, $urandom}, 4);
		idle_on = 1'b0;
		stall_on = 1'b0;
		hold_req = 1'b1;
		repeat (4) begin
			build_text(20, 1'b1);
			send_text(1'b1, 1'b1);
		end
	endtask

	task automatic run_search_phase(int items);
		int len_choices [10] = '{0, 1, 2, 3, 5, 8, 15, 16, 17, 31};
		logic [63:0] lo;
		logic [63:0] hi;
		int pmode;
		int len_code;
		int done;
		int tlen;
		bit cont;
		bit narrow;
		pmode = $urandom_range(0, 3);
		case (pmode)
			0: begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
			end
			1: begin
				for (int k = 0; k < 8; k++) begin
					lo[k*8 +: 8] = ($urandom_range(0, 1)) ? 8'h61 : 8'h62;
					hi[k*8 +: 8] = ($urandom_range(0, 1)) ? 8'h00 : 8'hFF;
				end
			end
			2: begin
				lo = '1;
				hi = '1;
			end
			default: begin
				lo = '0;
				hi = '0;
			end
		endcase
		len_code = ($urandom_range(0, 1)) ? len_choices[$urandom_range(0, 9)]
			: $urandom_range(1, MaxPattern);
		// Without a first flag the text carries on under the new length.
		cont = $urandom_range(0, 99) < 30;
		wait_idle();
		set_config(lo, hi, len_code);
		idle_on = $urandom_range(0, 3) != 0;
		stall_on = $urandom_range(0, 3) != 0;
		narrow = pmode != 0 || $urandom_range(0, 1);
		done = 0;
		while (done < items) begin
			tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
				: $urandom_range(1, 2 * active_len() + 6);
			build_text(tlen, narrow);
			send_text(!cont, $urandom_range(0, 9) != 0);
			cont = 1'b0;
			done += tlen;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		text_byte = '0;
		first_of_text = 1'b0;
		last_of_text = 1'b0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		hold_req = 1'b0;
		pat_lo = '0;
		pat_hi = '0;
		pat_len = 5'd1;
		for (int k = 0; k < MaxPattern; k++) text_window[k] = 8'h00;
		run_hash = '0;
		seen_bytes = '0;
		matched_once = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_short_patterns();
		test_full_length();
		test_output_hold_off();
		while (n_sent < ItemTarget) run_search_phase($urandom_range(60, 120));

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Sent %0d text bytes under %0d pattern settings; %0d results checked.",
			n_sent, n_cfg, n_checked);
		$display("Seen %0d first matches and %0d texts ending without one; %0d mismatches.",
			n_found, n_none, n_fail);
		if (n_fail == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
